/* sv/nearest_free_cell_spiral_search_unit_defines.svh */
// Assertion macros for the nearest free cell search unit.
// Expects clk and rst_n in the scope of each use.
`ifndef NEAREST_FREE_CELL_SPIRAL_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_FREE_CELL_SPIRAL_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication.
`define NFCS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfcs assertion failed");

// Next-cycle implication.
`define NFCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfcs assertion failed");

`endif

/* sv/nfcs_pkg.sv */
// Shared types, codes and table functions of the nearest free cell search unit.
// No dependencies.
package nfcs_pkg;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_ADJUSTED = 2'd1;
    localparam logic [1:0] ST_NO_MAP   = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    localparam logic [2:0] REG_COST_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_MAX_RINGS      = 3'd1;
    localparam logic [2:0] REG_ORIGIN_X       = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Y       = 3'd3;
    localparam logic [2:0] REG_CELL_SIZE      = 3'd4;
    localparam logic [2:0] REG_MAP_WIDTH      = 3'd5;
    localparam logic [2:0] REG_MAP_HEIGHT     = 3'd6;

    localparam logic [6:0]  RST_COST_THRESHOLD = 7'd50;
    localparam logic [7:0]  RST_MAX_RINGS      = 8'd40;
    localparam logic [22:0] RST_CELL_SIZE      = 23'd3277;
    localparam logic [16:0] RST_MAP_WIDTH      = 17'd256;
    localparam logic [16:0] RST_MAP_HEIGHT     = 17'd256;

    localparam logic signed [7:0] COST_UNKNOWN = -8'sd1;

    // Q30 over 0.05 m in Q16 is 327680 = 2^16 * 5; split as 2^16 then 5
    localparam logic [40:0] RING_HALF  = 41'd163840;
    localparam logic [23:0] RECIP5     = 24'd13421773;   // ceil(2^26 / 5)
    localparam int          RECIP5_SH  = 26;

    localparam longint ROT_C    = 64'sd1068377587;
    localparam longint ROT_S    = 64'sd107195315;
    localparam longint ONE_Q30  = 64'sd1073741824;
    localparam longint HALF_Q30 = 64'sd536870912;

    typedef struct packed {
        logic               req_type;
        logic [15:0]        cell_index;
        logic signed [7:0]  cell_cost;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [15:0] heading;
    } out_item_t;

    typedef struct packed {
        logic       load_cell;
        logic       start_query;
        logic       ld_mul;
        logic       ld_rnd;
        logic       ld_rec;
        logic       ld_sub;
        logic       div_start;
        logic       ld_idx;
        logic       ld_adr;
        logic       next_cand;
        logic       res_load;
        logic [1:0] res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic map_valid;
        logic div_done;
        logic free;
        logic last;
        logic at_goal;
        logic res_space;
    } dp_sts_t;

    // Cosine or sine after n rotations of 0.1 rad, Q2.30.
    function automatic longint rot_q30(input int n, input bit want_sin);
        longint c;
        longint s;
        longint nc;
        longint ns;
        c = ONE_Q30;
        s = 64'sd0;
        for (int i = 0; i < n; i++)
        begin
            nc = (c * ROT_C - s * ROT_S + HALF_Q30) >>> 30;
            ns = (s * ROT_C + c * ROT_S + HALF_Q30) >>> 30;
            c = nc;
            s = ns;
        end
        return want_sin ? s : c;
    endfunction

    // Angle step j * 0.1 rad minus pi, wrapped, Q3.13.
    function automatic logic signed [15:0] heading_q13(input int j);
        longint h;
        h = ((longint'(j) * 64'sd8192 + 64'sd5) / 64'sd10) % 64'sd51472;
        return 16'(h - 64'sd25736);
    endfunction

endpackage

/* sv/nfcs_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module nfcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/nfcs_div.sv */
// Two-lane restoring divider, one quotient bit per cycle, 32-bit dividends.
// No dependencies.
module nfcs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dvd_a,
    input  logic [31:0] dvd_b,
    input  logic [22:0] divisor,
    output logic        done,
    output logic [31:0] quo_a,
    output logic [31:0] quo_b
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [22:0] dv_reg, dv_next;
    logic [31:0] qa_reg, qa_next;
    logic [31:0] qb_reg, qb_next;
    logic [22:0] ra_reg, ra_next;
    logic [22:0] rb_reg, rb_next;
    logic [23:0] sha;
    logic [23:0] shb;
    logic        gea;
    logic        geb;

    always_comb
    begin
        sha = {ra_reg, qa_reg[31]};
        shb = {rb_reg, qb_reg[31]};
        gea = sha >= {1'b0, dv_reg};
        geb = shb >= {1'b0, dv_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dv_next   = dv_reg;
        qa_next   = qa_reg;
        qb_next   = qb_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 5'd0;
            dv_next  = divisor;
            qa_next  = dvd_a;
            qb_next  = dvd_b;
            ra_next  = 23'd0;
            rb_next  = 23'd0;
        end
        else if (run_reg)
        begin
            ra_next  = gea ? 23'(sha - {1'b0, dv_reg}) : 23'(sha);
            rb_next  = geb ? 23'(shb - {1'b0, dv_reg}) : 23'(shb);
            qa_next  = {qa_reg[30:0], gea};
            qb_next  = {qb_reg[30:0], geb};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg <= dv_next;
        qa_reg <= qa_next;
        qb_reg <= qb_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
    end

    assign done  = done_reg;
    assign quo_a = qa_reg;
    assign quo_b = qb_reg;

endmodule

/* sv/nfcs_dp.sv */
// Datapath: configuration registers, cost grid, candidate arithmetic, result register.
// Depends on nfcs_pkg, nfcs_ram and nfcs_div.
module nfcs_dp #(
    parameter int MAP_CELLS   = 65536,
    parameter int ANGLE_STEPS = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nfcs_pkg::in_item_t  in_data,
    input  logic                cfg_wr,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                out_stall,
    output logic                out_valid,
    output nfcs_pkg::out_item_t out_data,
    input  nfcs_pkg::dp_cmd_t   cmd,
    output nfcs_pkg::dp_sts_t   sts
);

    localparam int AW = $clog2(MAP_CELLS);
    localparam int JW = $clog2(ANGLE_STEPS);
    localparam logic [JW-1:0] LAST_J = JW'(ANGLE_STEPS - 1);

    logic signed [31:0] cos_tab  [ANGLE_STEPS];
    logic signed [31:0] sin_tab  [ANGLE_STEPS];
    logic signed [15:0] head_tab [ANGLE_STEPS];

    for (genvar g = 0; g < ANGLE_STEPS; g++)
    begin : g_tab
        assign cos_tab[g]  = 32'(nfcs_pkg::rot_q30(g, 1'b0));
        assign sin_tab[g]  = 32'(nfcs_pkg::rot_q30(g, 1'b1));
        assign head_tab[g] = nfcs_pkg::heading_q13(g);
    end

    // configuration and map state
    logic [6:0]         thr_reg;
    logic [7:0]         rings_reg;
    logic signed [31:0] orgx_reg;
    logic signed [31:0] orgy_reg;
    logic [22:0]        csize_reg;
    logic [16:0]        mw_reg;
    logic [16:0]        mh_reg;
    logic               map_valid_reg;

    // query state
    logic signed [31:0] gx_reg, gy_reg;
    logic [7:0]         k_reg;
    logic [JW-1:0]      j_reg;
    logic signed [40:0] px_reg, py_reg;
    logic [22:0]        tx_reg, ty_reg;
    logic               sx_reg, sy_reg;
    logic signed [20:0] dx_reg, dy_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic [31:0]        dva_reg, dvb_reg;
    logic               blk_reg;
    logic [33:0]        rowp_reg;
    logic [16:0]        colx_reg;

    logic               out_valid_reg;
    nfcs_pkg::out_item_t out_reg;

    // combinational helpers
    logic [40:0]        magx, magy;
    logic [19:0]        qx, qy;
    logic signed [20:0] qxs, qys;
    logic signed [33:0] cxw, cyw;
    logic signed [34:0] difx, dify;
    logic               range_bad;
    logic [34:0]        idx_w;
    logic [31:0]        quo_a, quo_b;
    logic               div_done;
    logic [22:0]        divisor;
    logic [7:0]         rdata;
    logic signed [7:0]  cost;
    logic               we;

    always_comb
    begin
        magx = px_reg[40] ? 41'(-px_reg) : 41'(px_reg);
        magy = py_reg[40] ? 41'(-py_reg) : 41'(py_reg);
        qx   = 20'((48'(tx_reg) * 48'(nfcs_pkg::RECIP5)) >> nfcs_pkg::RECIP5_SH);
        qy   = 20'((48'(ty_reg) * 48'(nfcs_pkg::RECIP5)) >> nfcs_pkg::RECIP5_SH);
        qxs  = $signed({1'b0, qx});
        qys  = $signed({1'b0, qy});
        cxw  = 34'(gx_reg) + 34'(dx_reg);
        cyw  = 34'(gy_reg) + 34'(dy_reg);
        difx = 35'(cxw) - 35'(orgx_reg);
        dify = 35'(cyw) - 35'(orgy_reg);
        range_bad = (cxw[33:31] != 3'b000 && cxw[33:31] != 3'b111)
                 || (cyw[33:31] != 3'b000 && cyw[33:31] != 3'b111);
        idx_w   = 35'(rowp_reg) + 35'(colx_reg);
        divisor = (csize_reg == 23'd0) ? 23'd1 : csize_reg;
        cost    = $signed(rdata);
        we      = cmd.load_cell && (32'(in_data.cell_index) < 32'(MAP_CELLS));
    end

    nfcs_ram #(
        .WIDTH (8),
        .DEPTH (MAP_CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(in_data.cell_index)),
        .wdata (in_data.cell_cost),
        .re    (cmd.ld_adr),
        .raddr (idx_w[AW-1:0]),
        .rdata (rdata)
    );

    nfcs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dvd_a   (dva_reg),
        .dvd_b   (dvb_reg),
        .divisor (divisor),
        .done    (div_done),
        .quo_a   (quo_a),
        .quo_b   (quo_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= nfcs_pkg::RST_COST_THRESHOLD;
            rings_reg     <= nfcs_pkg::RST_MAX_RINGS;
            orgx_reg      <= 32'sd0;
            orgy_reg      <= 32'sd0;
            csize_reg     <= nfcs_pkg::RST_CELL_SIZE;
            mw_reg        <= nfcs_pkg::RST_MAP_WIDTH;
            mh_reg        <= nfcs_pkg::RST_MAP_HEIGHT;
            map_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    nfcs_pkg::REG_COST_THRESHOLD: thr_reg   <= cfg_data[6:0];
                    nfcs_pkg::REG_MAX_RINGS:      rings_reg <= cfg_data[7:0];
                    nfcs_pkg::REG_ORIGIN_X:       orgx_reg  <= $signed(cfg_data);
                    nfcs_pkg::REG_ORIGIN_Y:       orgy_reg  <= $signed(cfg_data);
                    nfcs_pkg::REG_CELL_SIZE:      csize_reg <= cfg_data[22:0];
                    nfcs_pkg::REG_MAP_WIDTH:      mw_reg    <= cfg_data[16:0];
                    nfcs_pkg::REG_MAP_HEIGHT:     mh_reg    <= cfg_data[16:0];
                    default:                      ;
                endcase
            end
            if (cmd.load_cell)
            begin
                map_valid_reg <= 1'b1;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            gx_reg <= in_data.goal_x;
            gy_reg <= in_data.goal_y;
            k_reg  <= 8'd0;
            j_reg  <= '0;
        end
        if (cmd.next_cand)
        begin
            if (k_reg == 8'd0)
            begin
                k_reg <= 8'd1;
                j_reg <= '0;
            end
            else if (j_reg == LAST_J)
            begin
                k_reg <= k_reg + 8'd1;
                j_reg <= '0;
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
        if (cmd.ld_mul)
        begin
            px_reg <= 41'($signed({1'b0, k_reg}) * cos_tab[j_reg]);
            py_reg <= 41'($signed({1'b0, k_reg}) * sin_tab[j_reg]);
        end
        if (cmd.ld_rnd)
        begin
            tx_reg <= 23'((magx + nfcs_pkg::RING_HALF) >> 16);
            ty_reg <= 23'((magy + nfcs_pkg::RING_HALF) >> 16);
            sx_reg <= px_reg[40];
            sy_reg <= py_reg[40];
        end
        if (cmd.ld_rec)
        begin
            dx_reg <= sx_reg ? -qxs : qxs;
            dy_reg <= sy_reg ? -qys : qys;
        end
        if (cmd.ld_sub)
        begin
            cx_reg  <= cxw[31:0];
            cy_reg  <= cyw[31:0];
            dva_reg <= difx[31:0];
            dvb_reg <= dify[31:0];
            blk_reg <= range_bad || difx[34] || dify[34];
        end
        if (cmd.ld_idx)
        begin
            if (quo_a >= 32'(mw_reg) || quo_b >= 32'(mh_reg))
            begin
                blk_reg <= 1'b1;
            end
            rowp_reg <= 34'(quo_b[16:0]) * 34'(mw_reg);
            colx_reg <= quo_a[16:0];
        end
        if (cmd.ld_adr && idx_w >= 35'(MAP_CELLS))
        begin
            blk_reg <= 1'b1;
        end
        if (cmd.res_load)
        begin
            out_reg.status <= cmd.res_status;
            if (cmd.res_status == nfcs_pkg::ST_ADJUSTED)
            begin
                out_reg.out_x   <= cx_reg;
                out_reg.out_y   <= cy_reg;
                out_reg.heading <= head_tab[j_reg];
            end
            else
            begin
                out_reg.out_x   <= gx_reg;
                out_reg.out_y   <= gy_reg;
                out_reg.heading <= 16'sd0;
            end
        end
    end

    assign sts.map_valid = map_valid_reg;
    assign sts.div_done  = div_done;
    assign sts.free      = !blk_reg && cost != nfcs_pkg::COST_UNKNOWN
                           && cost < $signed({1'b0, thr_reg});
    assign sts.last      = (k_reg == rings_reg) && (k_reg == 8'd0 || j_reg == LAST_J);
    assign sts.at_goal   = (k_reg == 8'd0);
    assign sts.res_space = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* sv/nfcs_ctrl.sv */
// Controller: accepts transactions and sequences each tried point through the datapath.
// Depends on nfcs_pkg and the assertion macro header.
`include "nearest_free_cell_spiral_search_unit_defines.svh"

module nfcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              req_type,
    output logic              in_stall,
    output nfcs_pkg::dp_cmd_t cmd,
    input  nfcs_pkg::dp_sts_t sts
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_MUL    = 11'b00000000010,
        S_RND    = 11'b00000000100,
        S_REC    = 11'b00000001000,
        S_SUB    = 11'b00000010000,
        S_DSTART = 11'b00000100000,
        S_DWAIT  = 11'b00001000000,
        S_IDX    = 11'b00010000000,
        S_ADR    = 11'b00100000000,
        S_CHK    = 11'b01000000000,
        S_FIN    = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] res_reg, res_next;
    logic       accept;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        accept     = in_valid && !in_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req_type == nfcs_pkg::REQ_LOAD)
                begin
                    cmd.load_cell = 1'b1;
                end
                else if (accept)
                begin
                    cmd.start_query = 1'b1;
                    if (!sts.map_valid)
                    begin
                        res_next   = nfcs_pkg::ST_NO_MAP;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.ld_mul = 1'b1;
                state_next = S_RND;
            end
            S_RND:
            begin
                cmd.ld_rnd = 1'b1;
                state_next = S_REC;
            end
            S_REC:
            begin
                cmd.ld_rec = 1'b1;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.ld_sub = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = S_IDX;
                end
            end
            S_IDX:
            begin
                cmd.ld_idx = 1'b1;
                state_next = S_ADR;
            end
            S_ADR:
            begin
                cmd.ld_adr = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.free)
                begin
                    res_next   = sts.at_goal ? nfcs_pkg::ST_FREE : nfcs_pkg::ST_ADJUSTED;
                    state_next = S_FIN;
                end
                else if (sts.last)
                begin
                    res_next   = nfcs_pkg::ST_REJECTED;
                    state_next = S_FIN;
                end
                else
                begin
                    // advance to the next angle, or the next ring
                    cmd.next_cand = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_FIN:
            begin
                cmd.res_status = res_reg;
                if (sts.res_space)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= nfcs_pkg::ST_FREE;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    `NFCS_ASSERT_IMPL(a_res_space, cmd.res_load, sts.res_space)
    `NFCS_ASSERT_NEXT(a_div_follows, state_reg == S_DSTART, state_reg == S_DWAIT)
    `NFCS_ASSERT_NEXT(a_free_ends, state_reg == S_CHK && sts.free, state_reg == S_FIN)
    `NFCS_ASSERT_IMPL(a_load_idle, cmd.load_cell, state_reg == S_IDLE && !cmd.start_query)

endmodule

/* sv/nearest_free_cell_spiral_search_unit.sv */
// Load item: accepted whenever the unit is idle, no result.
// Query: with no map, status no map goes to the output; otherwise each tried point
// (goal first, then ring by ring) runs multiply, round, reciprocal, subtract, 32-step
// cell divider, index, address and check states. One item at a time; the result waits
// in an output register. Reset (rst_n, asynchronous, active low) clears the map valid
// flag and loads the default registers; the cost grid holds no reset value.
module nearest_free_cell_spiral_search_unit #(
    parameter int MAP_CELLS   = 65536,
    parameter int ANGLE_STEPS = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nfcs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output nfcs_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    nfcs_pkg::dp_cmd_t cmd;
    nfcs_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    nfcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_data.req_type),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    nfcs_dp #(
        .MAP_CELLS   (MAP_CELLS),
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
